// ===== src/sqvg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite quad vertex generator package
// shared types, fixed-point constants, rom builder and saturation helpers
// ----------------------------------------------------------------------------
package sqvg_pkg;

  // stream widths
  localparam int unsigned InDataW  = 384;
  localparam int unsigned OutDataW = 160;

  // angle scaling: q = floor(|rot| * table_size * 50000 / (314159 * 2^16))
  localparam logic [31:0] AngleMul  = 32'd50000;
  localparam logic [67:0] AngleDiv  = 68'd314159;
  localparam int unsigned RecipShift = 67;
  localparam logic [67:0] RecipPow  = 68'd1 << RecipShift;
  localparam logic [67:0] RecipVal  = (RecipPow + AngleDiv - 68'd1) / AngleDiv;
  localparam logic [24:0] RecipHi   = RecipVal[48:24];
  localparam logic [23:0] RecipLo   = RecipVal[23:0];
  localparam int unsigned ProdW     = 98;

  // datapath widths
  localparam int unsigned MatW    = 32;
  localparam int unsigned OffW    = 38;
  localparam int unsigned AnchorW = 40;
  localparam int unsigned SumW    = 42;

  localparam logic [1:0] CornerLast = 2'd3;

  // cosine series constants
  localparam logic [63:0] TwoPiQ28  = 64'd1686629713;
  localparam int unsigned SeriesLen = 10;

  localparam logic signed [SumW-1:0] PosMax = 42'sd2147483647;
  localparam logic signed [SumW-1:0] PosMin = -42'sd2147483648;
  localparam logic signed [16:0]     TexMax = 17'sd32767;
  localparam logic signed [16:0]     TexMin = -17'sd32768;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic               manual_active;
    logic [63:0]        manual_matrix;
    logic [63:0]        tex_rect;
    logic [63:0]        colour;
  } sprite_t;

  typedef struct packed {
    logic signed [AnchorW-1:0] px;
    logic signed [AnchorW-1:0] py;
    logic signed [MatW-1:0]    m00;
    logic signed [MatW-1:0]    m01;
    logic signed [MatW-1:0]    m10;
    logic signed [MatW-1:0]    m11;
    logic signed [15:0]        u0;
    logic signed [15:0]        u1;
    logic signed [15:0]        v0;
    logic signed [15:0]        v1;
    logic [63:0]               colour;
  } quad_t;

  typedef struct packed {
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic signed [15:0] tex_u;
    logic signed [15:0] tex_v;
  } vertex_t;

  typedef struct packed {
    vertex_t     vtx;
    logic [63:0] colour;
    logic [1:0]  corner;
    logic        last_corner;
  } out_item_t;

  // half-amplitude cosine for one rom entry, u is the phase in q32 turns
  function automatic logic signed [15:0] cos_rom_entry(input logic [63:0] u_in);
    logic [63:0]        u;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] r;
    logic               neg;
    u   = u_in;
    neg = 1'b0;
    if (u > (64'd1 << 31)) u = (64'd1 << 32) - u;
    if (u > (64'd1 << 30)) begin
      u   = (64'd1 << 31) - u;
      neg = 1'b1;
    end
    x    = (u * TwoPiQ28) >> 30;
    x2   = (x * x) >> 30;
    term = 64'd1 << 30;
    sum  = $signed(term);
    // term k is divided by (2k-1)(2k)
    for (int k = 1; k <= SeriesLen; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
      if (k[0]) sum = sum - $signed(term);
      else sum = sum + $signed(term);
    end
    if (sum < 0) sum = '0;
    r = (sum + 64'sd262144) >>> 19;
    return neg ? 16'(-r) : 16'(r);
  endfunction

  function automatic logic signed [31:0] sat_pos(input logic signed [SumW-1:0] v);
    if (v > PosMax) return 32'sh7fffffff;
    if (v < PosMin) return 32'sh80000000;
    return 32'(v);
  endfunction

  function automatic logic signed [15:0] sat_tex(input logic signed [16:0] v);
    if (v > TexMax) return 16'sh7fff;
    if (v < TexMin) return 16'sh8000;
    return 16'(v);
  endfunction

endpackage

// ===== src/sqvg_angle.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqvg angle index
// four-stage pipeline turning the rotation into a cosine rom index
// ----------------------------------------------------------------------------
module sqvg_angle import sqvg_pkg::*; #(
  parameter int unsigned TABLE_SIZE = 1024,
  localparam int unsigned IdxW = $clog2(TABLE_SIZE)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] rotation_i,
  input  sprite_t            spr_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [IdxW-1:0]    idx_o,
  output sprite_t            spr_o
);

  localparam logic [31:0]     AngleK  = 32'(TABLE_SIZE) * AngleMul;
  localparam logic [IdxW-1:0] IdxMask = IdxW'(TABLE_SIZE - 1);

  logic rdy1, rdy2, rdy3, rdy4;

  // stage 1: magnitude and sign
  logic        s1_v_q, s1_neg_q;
  logic [31:0] s1_mag_q;
  sprite_t     s1_spr_q;
  // stage 2: scaled angle
  logic        s2_v_q, s2_neg_q;
  logic [47:0] s2_n_q;
  sprite_t     s2_spr_q;
  // stage 3: reciprocal partial products
  logic        s3_v_q, s3_neg_q;
  logic [48:0] s3_hh_q, s3_lh_q;
  logic [47:0] s3_hl_q, s3_ll_q;
  sprite_t     s3_spr_q;
  // stage 4: index
  logic            s4_v_q;
  logic [IdxW-1:0] s4_idx_q;
  sprite_t         s4_spr_q;

  logic [31:0]      mag_d;
  logic [63:0]      prod_d;
  logic [ProdW-1:0] total_d;
  logic [IdxW-1:0]  q_lo, idx_d;

  assign rdy4       = !s4_v_q || out_ready_i;
  assign rdy3       = !s3_v_q || rdy4;
  assign rdy2       = !s2_v_q || rdy3;
  assign rdy1       = !s1_v_q || rdy2;
  assign in_ready_o = rdy1;

  assign mag_d  = rotation_i[31] ? (32'd0 - rotation_i) : rotation_i;
  assign prod_d = {32'd0, s1_mag_q} * {32'd0, AngleK};

  assign total_d = (ProdW'(s3_hh_q) << 48)
                 + ((ProdW'(s3_hl_q) + ProdW'(s3_lh_q)) << 24)
                 + ProdW'(s3_ll_q);
  assign q_lo  = total_d[RecipShift +: IdxW];
  assign idx_d = (s3_neg_q ? (IdxW'(0) - q_lo) : q_lo) & IdxMask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else begin
      if (rdy1) s1_v_q <= in_valid_i;
      if (rdy2) s2_v_q <= s1_v_q;
      if (rdy3) s3_v_q <= s2_v_q;
      if (rdy4) s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      s1_neg_q <= rotation_i[31];
      s1_mag_q <= mag_d;
      s1_spr_q <= spr_i;
    end
    if (rdy2) begin
      s2_neg_q <= s1_neg_q;
      s2_n_q   <= prod_d[63:16];
      s2_spr_q <= s1_spr_q;
    end
    if (rdy3) begin
      s3_neg_q <= s2_neg_q;
      s3_hh_q  <= 49'(s2_n_q[47:24]) * 49'(RecipHi);
      s3_hl_q  <= 48'(s2_n_q[47:24]) * 48'(RecipLo);
      s3_lh_q  <= 49'(s2_n_q[23:0]) * 49'(RecipHi);
      s3_ll_q  <= 48'(s2_n_q[23:0]) * 48'(RecipLo);
      s3_spr_q <= s2_spr_q;
    end
    if (rdy4) begin
      s4_idx_q <= idx_d;
      s4_spr_q <= s3_spr_q;
    end
  end

  assign out_valid_o = s4_v_q;
  assign idx_o       = s4_idx_q;
  assign spr_o       = s4_spr_q;

endmodule

// ===== src/sqvg_cos_rom.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqvg cosine rom
// half-amplitude cosine table with two registered read ports
// ----------------------------------------------------------------------------
module sqvg_cos_rom import sqvg_pkg::*; #(
  parameter int unsigned TABLE_SIZE = 1024,
  localparam int unsigned IdxW = $clog2(TABLE_SIZE)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [IdxW-1:0]    idx_i,
  input  sprite_t            spr_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] cos_o,
  output logic signed [15:0] sin_o,
  output sprite_t            spr_o
);

  localparam logic [IdxW-1:0] IdxMask    = IdxW'(TABLE_SIZE - 1);
  localparam logic [IdxW-1:0] QuarterOff = IdxW'(TABLE_SIZE / 4);

  logic signed [15:0] rom_w [TABLE_SIZE];

  for (genvar f = 0; f < TABLE_SIZE; f++) begin : g_rom
    localparam logic [63:0] UVal = (64'(f) << 32) / 64'(TABLE_SIZE);
    localparam logic signed [15:0] Entry = cos_rom_entry(UVal);
    assign rom_w[f] = Entry;
  end

  logic               v_q, rdy;
  logic [IdxW-1:0]    idq;
  logic signed [15:0] cos_q, sin_q;
  sprite_t            spr_q;

  // quarter-turn offset gives the second lookup, cos(a + pi/2) = -sin(a)
  assign idq        = (idx_i + QuarterOff) & IdxMask;
  assign rdy        = !v_q || out_ready_i;
  assign in_ready_o = rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (rdy) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy) begin
      cos_q <= rom_w[idx_i];
      sin_q <= rom_w[idq];
      spr_q <= spr_i;
    end
  end

  assign out_valid_o = v_q;
  assign cos_o       = cos_q;
  assign sin_o       = sin_q;
  assign spr_o       = spr_q;

endmodule

// ===== src/sqvg_matrix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqvg matrix and anchor
// three stages: 2x2 matrix, pivot offset products, shifted anchor
// ----------------------------------------------------------------------------
module sqvg_matrix import sqvg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] cos_i,
  input  logic signed [15:0] sin_i,
  input  sprite_t            spr_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output quad_t              quad_o
);

  logic rdy1, rdy2, rdy3;

  logic                   s1_v_q;
  logic signed [MatW-1:0] s1_m00_q, s1_m01_q, s1_m10_q, s1_m11_q;
  sprite_t                s1_spr_q;

  logic                   s2_v_q;
  logic signed [MatW-1:0] s2_m00_q, s2_m01_q, s2_m10_q, s2_m11_q;
  logic signed [OffW-1:0] s2_t00_q, s2_t10_q, s2_t01_q, s2_t11_q;
  sprite_t                s2_spr_q;

  logic  s3_v_q;
  quad_t s3_quad_q;

  logic signed [16:0]     cos_neg;
  logic signed [47:0]     p00, p01, p10, p11;
  logic signed [MatW-1:0] m00_d, m01_d, m10_d, m11_d;
  logic signed [17:0]     dx, dy;
  logic signed [49:0]     o00, o10, o01, o11;
  logic signed [15:0]     tx, ty, tw, th;
  quad_t                  quad_d;

  assign rdy3       = !s3_v_q || out_ready_i;
  assign rdy2       = !s2_v_q || rdy3;
  assign rdy1       = !s1_v_q || rdy2;
  assign in_ready_o = rdy1;

  // matrix: rom times scale, or manual entries widened to q16.16 and halved
  assign cos_neg = -17'(cos_i);
  assign p00     = 48'(cos_i) * 48'(spr_i.scale_x);
  assign p01     = 48'(sin_i) * 48'(spr_i.scale_x);
  assign p10     = 48'(sin_i) * 48'(spr_i.scale_y);
  assign p11     = 48'(cos_neg) * 48'(spr_i.scale_y);

  always_comb begin
    if (spr_i.manual_active) begin
      m00_d = 32'($signed(spr_i.manual_matrix[15:0])) <<< 3;
      m01_d = 32'($signed(spr_i.manual_matrix[31:16])) <<< 3;
      m10_d = 32'($signed(spr_i.manual_matrix[47:32])) <<< 3;
      m11_d = 32'($signed(spr_i.manual_matrix[63:48])) <<< 3;
    end else begin
      m00_d = 32'(p00 >>> 12);
      m01_d = 32'(p01 >>> 12);
      m10_d = 32'(p10 >>> 12);
      m11_d = 32'(p11 >>> 12);
    end
  end

  // pivot offset 2*(origin - 0.5) in q4.12
  assign dx  = (18'($signed(s1_spr_q.origin_x)) - 18'sd2048) <<< 1;
  assign dy  = (18'($signed(s1_spr_q.origin_y)) - 18'sd2048) <<< 1;
  assign o00 = 50'(dx) * 50'(s1_m00_q);
  assign o10 = 50'(dy) * 50'(s1_m10_q);
  assign o01 = 50'(dx) * 50'(s1_m01_q);
  assign o11 = 50'(dy) * 50'(s1_m11_q);

  assign tx = $signed(s2_spr_q.tex_rect[15:0]);
  assign ty = $signed(s2_spr_q.tex_rect[31:16]);
  assign tw = $signed(s2_spr_q.tex_rect[47:32]);
  assign th = $signed(s2_spr_q.tex_rect[63:48]);

  always_comb begin
    quad_d.px     = AnchorW'(s2_spr_q.pos_x) - AnchorW'(s2_t00_q) - AnchorW'(s2_t10_q);
    quad_d.py     = AnchorW'(s2_spr_q.pos_y) - AnchorW'(s2_t01_q) - AnchorW'(s2_t11_q);
    quad_d.m00    = s2_m00_q;
    quad_d.m01    = s2_m01_q;
    quad_d.m10    = s2_m10_q;
    quad_d.m11    = s2_m11_q;
    quad_d.u0     = tx;
    quad_d.u1     = sat_tex(17'(tx) + 17'(tw));
    quad_d.v0     = ty;
    quad_d.v1     = sat_tex(17'(ty) + 17'(th));
    quad_d.colour = s2_spr_q.colour;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (rdy1) s1_v_q <= in_valid_i;
      if (rdy2) s2_v_q <= s1_v_q;
      if (rdy3) s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      s1_m00_q <= m00_d;
      s1_m01_q <= m01_d;
      s1_m10_q <= m10_d;
      s1_m11_q <= m11_d;
      s1_spr_q <= spr_i;
    end
    if (rdy2) begin
      s2_m00_q <= s1_m00_q;
      s2_m01_q <= s1_m01_q;
      s2_m10_q <= s1_m10_q;
      s2_m11_q <= s1_m11_q;
      s2_t00_q <= OffW'(o00 >>> 12);
      s2_t10_q <= OffW'(o10 >>> 12);
      s2_t01_q <= OffW'(o01 >>> 12);
      s2_t11_q <= OffW'(o11 >>> 12);
      s2_spr_q <= s1_spr_q;
    end
    if (rdy3) begin
      s3_quad_q <= quad_d;
    end
  end

  assign out_valid_o = s3_v_q;
  assign quad_o      = s3_quad_q;

endmodule

// ===== src/sqvg_corner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqvg corner emitter
// four corner lanes into a holding stage, then one vertex per cycle out while the output is ready
// ----------------------------------------------------------------------------
module sqvg_corner import sqvg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  quad_t     quad_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t item_o
);

  vertex_t     vert_d [4];
  vertex_t     vert_q [4];
  logic [63:0] colour_q;
  logic        hold_v_q;
  logic [1:0]  cnt_q;
  logic        o_v_q;
  out_item_t   item_q;
  logic        o_load, hold_done;

  // corner k: a = + on 1,2 ; b = + on 2,3
  for (genvar k = 0; k < 4; k++) begin : g_lane
    localparam logic APos = (k == 1) || (k == 2);
    localparam logic BPos = (k >= 2);
    logic signed [SumW-1:0] sx, sy;
    always_comb begin
      sx = SumW'(quad_i.px);
      sy = SumW'(quad_i.py);
      sx = APos ? sx + SumW'(quad_i.m00) : sx - SumW'(quad_i.m00);
      sy = APos ? sy + SumW'(quad_i.m01) : sy - SumW'(quad_i.m01);
      sx = BPos ? sx + SumW'(quad_i.m10) : sx - SumW'(quad_i.m10);
      sy = BPos ? sy + SumW'(quad_i.m11) : sy - SumW'(quad_i.m11);
      vert_d[k].vertex_x = sat_pos(sx);
      vert_d[k].vertex_y = sat_pos(sy);
      vert_d[k].tex_u    = APos ? quad_i.u1 : quad_i.u0;
      vert_d[k].tex_v    = BPos ? quad_i.v1 : quad_i.v0;
    end
  end

  assign o_load     = hold_v_q && (!o_v_q || out_ready_i);
  assign hold_done  = o_load && (cnt_q == CornerLast);
  assign in_ready_o = !hold_v_q || hold_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q <= 1'b0;
      cnt_q    <= '0;
      o_v_q    <= 1'b0;
    end else begin
      if (in_ready_o) hold_v_q <= in_valid_i;
      if (o_load) cnt_q <= cnt_q + 2'd1;
      if (o_load) o_v_q <= 1'b1;
      else if (out_ready_i) o_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      vert_q   <= vert_d;
      colour_q <= quad_i.colour;
    end
    if (o_load) begin
      item_q.vtx         <= vert_q[cnt_q];
      item_q.colour      <= colour_q;
      item_q.corner      <= cnt_q;
      item_q.last_corner <= (cnt_q == CornerLast);
    end
  end

  assign out_valid_o = o_v_q;
  assign item_o      = item_q;

endmodule

// ===== src/sprite_quad_vertex_generator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite quad vertex generator
// one sprite in, four quad corners out with position, texture and colour
// ----------------------------------------------------------------------------
//
//  channel   | dir | tdata (low bit up)                         | tuser          | tlast
//  ----------+-----+--------------------------------------------+----------------+------------
//  s_axis    | in  | pos_x pos_y rotation scale_x scale_y        | manual_active  | -
//            |     | origin_x origin_y manual_matrix tex_rect    |                |
//            |     | colour (384 bits)                          |                |
//  m_axis    | out | vertex_x vertex_y tex_u tex_v vertex_colour | corner         | last_corner
//            |     | (160 bits)                                 |                |
//
//  a sprite produces four output items, one per cycle while m_axis_tready is high,
//  so the single output port sets the sustained sprite rate
//  after the sprite is taken, the first corner passes 4 angle stages, the rom read,
//  3 matrix stages, the corner lanes into the holding stage and the output register
//  reset clears only valid bits and the corner counter; the rom is constant
//  either side may stall at any time: every stage holds until the next frees
//
module sprite_quad_vertex_generator_top import sqvg_pkg::*; #(
  parameter int unsigned TABLE_SIZE = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // pos_x, pos_y, rotation, scale_x, scale_y, origin_x, origin_y,
  // manual_matrix, tex_rect, colour
  input  logic [InDataW-1:0]  s_axis_tdata,
  // manual_active
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // vertex_x, vertex_y, tex_u, tex_v, vertex_colour
  output logic [OutDataW-1:0] m_axis_tdata,
  // corner
  output logic [1:0]          m_axis_tuser,
  output logic                m_axis_tlast
);

  localparam int unsigned IdxW = $clog2(TABLE_SIZE);

  sprite_t            in_spr;
  logic signed [31:0] in_rot;

  // angle pipeline to rom
  logic            ang_valid, ang_ready;
  logic [IdxW-1:0] ang_idx;
  sprite_t         ang_spr;

  // rom to matrix
  logic               rom_valid, rom_ready;
  logic signed [15:0] rom_cos, rom_sin;
  sprite_t            rom_spr;

  // matrix to corner emitter
  logic  mat_valid, mat_ready;
  quad_t mat_quad;

  out_item_t out_item;

  // unpack the input item
  assign in_spr.pos_x         = s_axis_tdata[31:0];
  assign in_spr.pos_y         = s_axis_tdata[63:32];
  assign in_rot               = s_axis_tdata[95:64];
  assign in_spr.scale_x       = s_axis_tdata[127:96];
  assign in_spr.scale_y       = s_axis_tdata[159:128];
  assign in_spr.origin_x      = s_axis_tdata[175:160];
  assign in_spr.origin_y      = s_axis_tdata[191:176];
  assign in_spr.manual_matrix = s_axis_tdata[255:192];
  assign in_spr.tex_rect      = s_axis_tdata[319:256];
  assign in_spr.colour        = s_axis_tdata[383:320];
  assign in_spr.manual_active = s_axis_tuser;

  // rotation to rom index; runs for manual sprites too and is ignored there
  sqvg_angle #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_angle (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .rotation_i  (in_rot),
    .spr_i       (in_spr),
    .out_valid_o (ang_valid),
    .out_ready_i (ang_ready),
    .idx_o       (ang_idx),
    .spr_o       (ang_spr)
  );

  // cosine and quarter-turn shifted cosine lookups
  sqvg_cos_rom #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_rom (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (ang_valid),
    .in_ready_o  (ang_ready),
    .idx_i       (ang_idx),
    .spr_i       (ang_spr),
    .out_valid_o (rom_valid),
    .out_ready_i (rom_ready),
    .cos_o       (rom_cos),
    .sin_o       (rom_sin),
    .spr_o       (rom_spr)
  );

  // matrix build, pivot offset and anchor shift
  sqvg_matrix u_matrix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rom_valid),
    .in_ready_o  (rom_ready),
    .cos_i       (rom_cos),
    .sin_i       (rom_sin),
    .spr_i       (rom_spr),
    .out_valid_o (mat_valid),
    .out_ready_i (mat_ready),
    .quad_o      (mat_quad)
  );

  // four corners, then serialized onto the output stream
  sqvg_corner u_corner (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mat_valid),
    .in_ready_o  (mat_ready),
    .quad_i      (mat_quad),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .item_o      (out_item)
  );

  assign m_axis_tdata = {out_item.colour, out_item.vtx.tex_v, out_item.vtx.tex_u,
                         out_item.vtx.vertex_y, out_item.vtx.vertex_x};
  assign m_axis_tuser = out_item.corner;
  assign m_axis_tlast = out_item.last_corner;

endmodule
